// File: design/mandelbrot_escape_time_pixel_assert.svh
// Assertion macros used by the Mandelbrot escape-time pixel controller
`ifndef MANDELBROT_ESCAPE_TIME_PIXEL_ASSERT_SVH
`define MANDELBROT_ESCAPE_TIME_PIXEL_ASSERT_SVH
`ifndef SYNTHESIS
`define MBET_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("mbet: assertion failed");
`define MBET_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("mbet: assertion failed");
`else
`define MBET_ASSERT(lbl, clk, rstn, prop)
`define MBET_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// File: design/mbet_pkg.sv
// Types and constants of the Mandelbrot escape-time pixel block
package mbet_pkg;

  localparam int unsigned COORD_BITS = 14;
  localparam int unsigned ITER_BITS  = 16;
  localparam int unsigned CFG_BITS   = 32;
  localparam int unsigned SIZE_BITS  = 15;
  localparam int unsigned STEP_BITS  = 31;
  localparam int unsigned LIM_BITS   = 16;
  localparam int unsigned GRAY_BITS  = 8;
  localparam int unsigned DIVN_BITS  = LIM_BITS + GRAY_BITS;
  localparam int unsigned OFS_BITS   =
    ((COORD_BITS > SIZE_BITS - 1) ? COORD_BITS : SIZE_BITS - 1) + 1;
  localparam int unsigned ESCAPE_LIMIT = 4;

  typedef enum logic [2:0] {
    CFG_IMAGE_WIDTH    = 3'd0,
    CFG_IMAGE_HEIGHT   = 3'd1,
    CFG_CENTER_RE      = 3'd2,
    CFG_CENTER_IM      = 3'd3,
    CFG_STEP_RE        = 3'd4,
    CFG_STEP_IM        = 3'd5,
    CFG_MAX_ITERATIONS = 3'd6
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OFFS,
    ST_ITER,
    ST_DIV,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
  } pix_in_t;

  typedef struct packed {
    logic [GRAY_BITS-1:0] gray_level;
    logic [ITER_BITS-1:0] iteration_count;
  } pix_out_t;

  typedef struct packed {
    logic [SIZE_BITS-1:0] image_width;
    logic [SIZE_BITS-1:0] image_height;
    logic [31:0]          center_re;
    logic [31:0]          center_im;
    logic [STEP_BITS-1:0] step_re;
    logic [STEP_BITS-1:0] step_im;
    logic [LIM_BITS-1:0]  max_iterations;
  } cfg_t;

  typedef struct packed {
    logic start;
    logic offs;
    logic iter_upd;
    logic iter_fin;
    logic div_step;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic iter_done;
  } dp_sts_t;

endpackage

// File: design/mbet_cfg.sv
// Configuration register file of the Mandelbrot pixel block
module mbet_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [2:0]                         cfg_idx_i,
  input  logic [mbet_pkg::CFG_BITS-1:0]      cfg_data_i,
  output mbet_pkg::cfg_t                     cfg_o
);
  import mbet_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_IMAGE_WIDTH:    cfg_d.image_width    = cfg_data_i[SIZE_BITS-1:0];
        CFG_IMAGE_HEIGHT:   cfg_d.image_height   = cfg_data_i[SIZE_BITS-1:0];
        CFG_CENTER_RE:      cfg_d.center_re      = cfg_data_i;
        CFG_CENTER_IM:      cfg_d.center_im      = cfg_data_i;
        CFG_STEP_RE:        cfg_d.step_re        = cfg_data_i[STEP_BITS-1:0];
        CFG_STEP_IM:        cfg_d.step_im        = cfg_data_i[STEP_BITS-1:0];
        CFG_MAX_ITERATIONS: cfg_d.max_iterations = cfg_data_i[LIM_BITS-1:0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width    <= SIZE_BITS'(8192);
      cfg_q.image_height   <= SIZE_BITS'(4096);
      cfg_q.center_re      <= 32'd174483046;
      cfg_q.center_im      <= 32'd0;
      cfg_q.step_re        <= STEP_BITS'(131072);
      cfg_q.step_im        <= STEP_BITS'(131072);
      cfg_q.max_iterations <= LIM_BITS'(100);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: design/mbet_dp.sv
// Datapath: coordinate mapping, complex square iteration and gray divider
module mbet_dp #(
  parameter int unsigned FRAC_BITS = 28
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mbet_pkg::cfg_t    cfg_i,
  input  mbet_pkg::pix_in_t in_data_i,
  input  mbet_pkg::dp_cmd_t cmd_i,
  output mbet_pkg::dp_sts_t sts_o,
  output mbet_pkg::pix_out_t out_data_o
);
  import mbet_pkg::*;

  localparam int unsigned W   = FRAC_BITS + 4;
  localparam int unsigned P   = 2 * W;
  localparam int unsigned SQW = P - FRAC_BITS;
  localparam int unsigned MW  = OFS_BITS + STEP_BITS + 1;
  localparam logic [SQW:0] BOUND = (SQW + 1)'(ESCAPE_LIMIT) << FRAC_BITS;

  logic [OFS_BITS-1:0]       dx, dy;
  logic signed [MW-1:0]      px, py;
  logic signed [63:0]        cen_re64, cen_im64;
  logic [W-1:0]              map_re_q, map_im_q;
  logic signed [W-1:0]       cr_q, ci_q, zr_q, zi_q, zr_d, zi_d;
  logic signed [P-1:0]       sq_r, sq_i, sq_x;
  logic [SQW-1:0]            rr, ii, ri;
  logic [SQW:0]              mag;
  logic                      esc;
  logic [LIM_BITS-1:0]       n_q, k_q, k_d;
  logic [DIVN_BITS-1:0]      rem_q, dsh_q;
  logic [GRAY_BITS-1:0]      quot_q;
  pix_out_t                  out_q;

  // map pixel to plane, low word bits only
  assign dx = OFS_BITS'(in_data_i.pixel_x) - OFS_BITS'(cfg_i.image_width[SIZE_BITS-1:1]);
  assign dy = OFS_BITS'(in_data_i.pixel_y) - OFS_BITS'(cfg_i.image_height[SIZE_BITS-1:1]);
  assign px = $signed(dx) * $signed({1'b0, cfg_i.step_re});
  assign py = $signed(dy) * $signed({1'b0, cfg_i.step_im});
  assign cen_re64 = 64'($signed(cfg_i.center_re));
  assign cen_im64 = 64'($signed(cfg_i.center_im));

  // one iteration of z = z^2 + c
  assign sq_r = zr_q * zr_q;
  assign sq_i = zi_q * zi_q;
  assign sq_x = zr_q * zi_q;
  assign rr   = sq_r[P-1:FRAC_BITS];
  assign ii   = sq_i[P-1:FRAC_BITS];
  assign ri   = sq_x[P-1:FRAC_BITS];
  assign mag  = {1'b0, rr} + {1'b0, ii};
  assign esc  = (n_q != '0) && (mag > BOUND);
  assign zr_d = rr[W-1:0] - ii[W-1:0] + cr_q;
  assign zi_d = {ri[W-2:0], 1'b0} + ci_q;
  assign k_d  = esc ? LIM_BITS'(n_q - LIM_BITS'(1)) : n_q;

  assign sts_o.iter_done = esc || (n_q == cfg_i.max_iterations);

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      map_re_q <= px[W-1:0];
      map_im_q <= py[W-1:0];
    end
    if (cmd_i.offs) begin
      cr_q <= map_re_q - cen_re64[W-1:0];
      ci_q <= map_im_q - cen_im64[W-1:0];
      zr_q <= map_re_q - cen_re64[W-1:0];
      zi_q <= map_im_q - cen_im64[W-1:0];
    end else if (cmd_i.iter_upd) begin
      zr_q <= zr_d;
      zi_q <= zi_d;
    end
    if (cmd_i.iter_fin) begin
      k_q    <= k_d;
      rem_q  <= {k_d, GRAY_BITS'(0)} - DIVN_BITS'(k_d);
      dsh_q  <= DIVN_BITS'({cfg_i.max_iterations, (GRAY_BITS - 1)'(0)});
      quot_q <= '0;
    end else if (cmd_i.div_step) begin
      if ((cfg_i.max_iterations != '0) && (rem_q >= dsh_q)) begin
        rem_q  <= rem_q - dsh_q;
        quot_q <= {quot_q[GRAY_BITS-2:0], 1'b1};
      end else begin
        quot_q <= {quot_q[GRAY_BITS-2:0], 1'b0};
      end
      dsh_q <= dsh_q >> 1;
    end
    if (cmd_i.load_out) begin
      out_q.gray_level      <= quot_q;
      out_q.iteration_count <= ITER_BITS'(k_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q <= '0;
    end else if (cmd_i.offs) begin
      n_q <= '0;
    end else if (cmd_i.iter_upd) begin
      n_q <= LIM_BITS'(n_q + LIM_BITS'(1));
    end
  end

  assign out_data_o = out_q;

endmodule

// File: design/mbet_ctrl.sv
// Controller state machine of the Mandelbrot pixel block
`include "mandelbrot_escape_time_pixel_assert.svh"
module mbet_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  mbet_pkg::dp_sts_t sts_i,
  output mbet_pkg::dp_cmd_t cmd_o
);
  import mbet_pkg::*;

  localparam int unsigned DIV_STEPS = GRAY_BITS;
  localparam int unsigned DCW = $clog2(DIV_STEPS);

  state_e         state_q, state_d;
  logic [DCW-1:0] div_cnt_q, div_cnt_d;
  logic           out_valid_q, out_valid_d;
  logic           out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_OFFS;
      ST_OFFS: state_d = ST_ITER;
      ST_ITER: if (sts_i.iter_done) state_d = ST_DIV;
      ST_DIV:  if (div_cnt_q == DCW'(DIV_STEPS - 1)) state_d = ST_DONE;
      ST_DONE: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    div_cnt_d  = div_cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.start  = in_valid_i;
      end
      ST_OFFS: cmd_o.offs = 1'b1;
      ST_ITER: begin
        cmd_o.iter_fin = sts_i.iter_done;
        cmd_o.iter_upd = !sts_i.iter_done;
        div_cnt_d      = '0;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        div_cnt_d      = DCW'(div_cnt_q + DCW'(1));
      end
      ST_DONE: cmd_o.load_out = out_free;
      default: cmd_o = '0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    priority if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      div_cnt_q   <= div_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `MBET_ASSERT(a_cmd_onehot, clk_i, rst_ni, $onehot0(cmd_o))
  `MBET_ASSERT(a_load_free, clk_i, rst_ni, cmd_o.load_out |-> out_free)
  `MBET_ASSERT_NEXT(a_start_offs, clk_i, rst_ni, cmd_o.start, state_q == ST_OFFS)
  `MBET_ASSERT_NEXT(a_div_begin, clk_i, rst_ni, cmd_o.iter_fin, state_q == ST_DIV && div_cnt_q == '0)
  `MBET_ASSERT_NEXT(a_out_rise, clk_i, rst_ni, !out_valid_q && !cmd_o.load_out, !out_valid_q)

endmodule

// File: design/mandelbrot_escape_time_pixel.sv
// Top level of the Mandelbrot escape-time pixel block
//
//   port group  direction  handshake            beat
//   in          to block   in_valid_i/in_stall_o    pixel_x, pixel_y
//   out         from block out_valid_o/out_stall_i  gray_level, iteration_count
//   cfg         to block   cfg_we_i                 cfg_idx_i, cfg_data_i
//
// The iteration loop runs one complex-square iteration per cycle until the point
// escapes or max_iterations updates have been done.
// Gray scaling is a restoring divider after the iteration loop.
// Reset is asynchronous and active low; it loads the default registers.
// The result register holds a finished beat while out_stall_i is high; a new
// pixel is taken once the previous result has been handed to that register.
module mandelbrot_escape_time_pixel #(
  parameter int unsigned FRAC_BITS = 28
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  mbet_pkg::pix_in_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output mbet_pkg::pix_out_t            out_data_o,
  input  logic                          cfg_we_i,
  input  logic [2:0]                    cfg_idx_i,
  input  logic [mbet_pkg::CFG_BITS-1:0] cfg_data_i
);
  import mbet_pkg::*;

  cfg_t    cfg;
  dp_cmd_t cmd;
  dp_sts_t sts;

  mbet_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  mbet_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  mbet_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule

// File: dv/mandelbrot_escape_time_pixel_tb.sv
// Self-checking testbench of the Mandelbrot escape-time pixel block
module mandelbrot_escape_time_pixel_tb;
  import mbet_pkg::*;

  localparam int FRAC = 28;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  pix_in_t             in_data_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  pix_out_t            out_data_o;
  logic                cfg_we_i = 1'b0;
  logic [2:0]          cfg_idx_i = '0;
  logic [CFG_BITS-1:0] cfg_data_i = '0;

  cfg_t        regs;
  pix_in_t     pending_pixels[$];
  pix_out_t    awaited_results[$];
  int unsigned mismatch_count = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  int unsigned pixels_queued = 0;
  bit          calm_in = 1'b0;
  bit          calm_out = 1'b0;

  mandelbrot_escape_time_pixel #(
    .FRAC_BITS(FRAC)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic longint wrap_word(longint v);
    logic signed [FRAC+3:0] t;
    t = v[FRAC+3:0];
    return longint'(t);
  endfunction

  function automatic longint fix_mul(longint a, longint b);
    longint p;
    p = a * b;
    return p >>> FRAC;
  endfunction

  function automatic longint map_axis(logic [COORD_BITS-1:0] pix, logic [SIZE_BITS-1:0] size,
                                      logic [STEP_BITS-1:0] step, logic [31:0] center);
    longint d;
    d = longint'(pix) - longint'(size >> 1);
    return wrap_word(d * longint'(step) - longint'($signed(center)));
  endfunction

  function automatic pix_out_t escape_time(pix_in_t p);
    longint      cr, ci, zr, zi, rr, ii, ri, bound;
    int unsigned k, lim;
    pix_out_t    r;
    cr = map_axis(p.pixel_x, regs.image_width, regs.step_re, regs.center_re);
    ci = map_axis(p.pixel_y, regs.image_height, regs.step_im, regs.center_im);
    zr = cr;
    zi = ci;
    bound = longint'(ESCAPE_LIMIT) << FRAC;
    lim = regs.max_iterations;
    k = 0;
    while (k < lim) begin
      rr = fix_mul(zr, zr);
      ii = fix_mul(zi, zi);
      ri = fix_mul(zr, zi);
      zr = wrap_word(rr - ii + cr);
      zi = wrap_word(2 * ri + ci);
      if (fix_mul(zr, zr) + fix_mul(zi, zi) > bound) break;
      k++;
    end
    r.iteration_count = ITER_BITS'(k);
    r.gray_level = (lim == 0) ? '0 : GRAY_BITS'((255 * k) / lim);
    return r;
  endfunction

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic cfg_t make_cfg(int unsigned w, int unsigned h, logic [31:0] cre,
                                    logic [31:0] cim, int unsigned sre, int unsigned sim,
                                    int unsigned lim);
    cfg_t c;
    c.image_width    = SIZE_BITS'(w);
    c.image_height   = SIZE_BITS'(h);
    c.center_re      = cre;
    c.center_im      = cim;
    c.step_re        = STEP_BITS'(sre);
    c.step_im        = STEP_BITS'(sim);
    c.max_iterations = LIM_BITS'(lim);
    return c;
  endfunction

  task automatic program_regs(input cfg_t c);
    logic [31:0] val;
    for (int i = 0; i <= int'(CFG_MAX_ITERATIONS); i++) begin
      case (cfg_idx_e'(i))
        CFG_IMAGE_WIDTH:    val = 32'(c.image_width);
        CFG_IMAGE_HEIGHT:   val = 32'(c.image_height);
        CFG_CENTER_RE:      val = c.center_re;
        CFG_CENTER_IM:      val = c.center_im;
        CFG_STEP_RE:        val = 32'(c.step_re);
        CFG_STEP_IM:        val = 32'(c.step_im);
        CFG_MAX_ITERATIONS: val = 32'(c.max_iterations);
        default:            val = '0;
      endcase
      @(posedge clk_i);
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= cfg_idx_e'(i);
      cfg_data_i <= val;
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    regs = c;
  endtask

  task automatic queue_pixel(int unsigned x, int unsigned y);
    pix_in_t p;
    p.pixel_x = COORD_BITS'(x);
    p.pixel_y = COORD_BITS'(y);
    pending_pixels.push_back(p);
    pixels_queued++;
  endtask

  task automatic drain();
    while (pending_pixels.size() != 0 || in_valid_i || awaited_results.size() != 0)
      @(negedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  // send pixel beats with random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
      gap_left = 0;
    end else begin
      if (in_valid_i && !in_stall_o) awaited_results.push_back(escape_time(in_data_i));
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_pixels.size() != 0) begin
          in_data_i  <= pending_pixels.pop_front();
          in_valid_i <= 1'b1;
          gap_left = (calm_in || $urandom_range(0, 2) == 0) ? 0 : idle_len();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // check result beats and stall at random
  always @(posedge clk_i or negedge rst_ni) begin
    pix_out_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (awaited_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected beat: gray %0d count %0d",
                     out_data_o.gray_level, out_data_o.iteration_count);
        end else begin
          want = awaited_results.pop_front();
          if (out_data_o.gray_level !== want.gray_level ||
              out_data_o.iteration_count !== want.iteration_count) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: expected gray %0d count %0d, got gray %0d count %0d",
                       want.gray_level, want.iteration_count,
                       out_data_o.gray_level, out_data_o.iteration_count);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (!calm_out && $urandom_range(0, 5) == 0) begin
        stall_left = idle_len() - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    #40_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int unsigned w, h, lim, n, x, y, sre, sim, mag;
    longint      ww, hh, aspect;
    logic [31:0] cre, cim;
    regs = make_cfg(8192, 4096, 32'd174483046, 32'd0, 131072, 131072, 100);
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // corners, first-update escape, points inside the set, bit patterns
    queue_pixel(0, 0);
    queue_pixel(16383, 16383);
    queue_pixel(0, 16383);
    queue_pixel(16383, 0);
    queue_pixel(5427, 2048);
    queue_pixel(4096, 2048);
    queue_pixel(14'h2aaa, 14'h1555);
    queue_pixel(14'h1555, 14'h2aaa);
    drain();

    // zero limit
    program_regs(make_cfg(8192, 4096, 32'd174483046, 32'd0, 131072, 131072, 0));
    queue_pixel(5427, 2048);
    queue_pixel(0, 0);
    drain();

    // wrap everything at the register extremes
    program_regs(make_cfg(32767, 0, 32'h7fff_ffff, 32'h8000_0000,
                          32'h7fff_ffff, 32'h7fff_ffff, 1));
    queue_pixel(0, 0);
    queue_pixel(16383, 16383);
    queue_pixel(14'h2aaa, 14'h1555);
    drain();

    // odd sizes, unit step
    program_regs(make_cfg(1, 3, 32'd0, 32'd0, 1 << FRAC, 1 << FRAC, 255));
    queue_pixel(0, 0);
    queue_pixel(0, 2);
    queue_pixel(1, 1);
    drain();

    // full limit on points that never escape
    program_regs(make_cfg(1, 1, 32'd0, 32'd0, 0, 0, 65535));
    queue_pixel(0, 0);
    drain();
    program_regs(make_cfg(1, 1, 32'hfc00_0000, 32'd0, 0, 0, 65535));
    queue_pixel(7, 9);
    drain();

    while (pixels_queued < 1850) begin
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 32767) : $urandom_range(1, 16384);
      h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 32767) : $urandom_range(1, 16384);
      if ($urandom_range(0, 9) < 8) begin
        ww = (w == 0) ? 1 : w;
        hh = (h == 0) ? 1 : h;
        aspect = (ww / hh < 1) ? 1 : ww / hh;
        mag = $urandom_range(1, 200);
        sre = int'((64'd1 << 30) / (mag * ww));
        sim = int'((64'd1 << 30) / (mag * hh * aspect));
        cre = 32'(longint'($urandom_range(0, 32'h4000_0000)) - 64'sh2000_0000);
        cim = 32'(longint'($urandom_range(0, 32'h4000_0000)) - 64'sh2000_0000);
      end else begin
        sre = $urandom;
        sim = $urandom;
        cre = $urandom;
        cim = $urandom;
      end
      lim = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 250) : $urandom_range(1, 100);
      program_regs(make_cfg(w, h, cre, cim, sre, sim, lim));
      calm_in = ($urandom_range(0, 3) == 0);
      calm_out = ($urandom_range(0, 3) == 0);
      n = $urandom_range(20, 80);
      repeat (n) begin
        if (w != 0 && h != 0 && $urandom_range(0, 4) != 0) begin
          x = $urandom_range(0, ((w > 16384) ? 16384 : w) - 1);
          y = $urandom_range(0, ((h > 16384) ? 16384 : h) - 1);
        end else begin
          x = $urandom_range(0, 16383);
          y = $urandom_range(0, 16383);
        end
        queue_pixel(x, y);
      end
      drain();
    end

    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
